>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising clock edge outside reset
`define BCC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("bcc port check failed");

// checked at every rising clock edge, reset included
`define BCC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("bcc reset check failed");

`endif

>>> rtl/bcc_pkg.sv
// types, constants and helpers of the biquad coefficient calculator
`default_nettype none
package bcc_pkg;

    localparam int COEFF_FRAC_BITS = 15;
    localparam int COEFF_W         = 18;
    localparam int ALPHA_SHIFT     = 15;

    // internal signed values, q.30
    localparam int VAL_W = 40;
    typedef logic signed [VAL_W-1:0] t_val;

    // serial multiplier
    localparam int MUL_A_W   = 34;
    localparam int MUL_B_W   = 32;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

    // serial divider
    localparam int DIV_N_W   = (COEFF_FRAC_BITS + 37 > 48) ? COEFF_FRAC_BITS + 37 : 48;
    localparam int DIV_D_W   = 37;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] num;
        logic [DIV_D_W-1:0] den;
    } t_div_req;

    // register indexes
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_OMEGA = 2'd1;

    // filter modes
    localparam logic [1:0] MODE_LP    = 2'd0;
    localparam logic [1:0] MODE_HP    = 2'd1;
    localparam logic [1:0] MODE_BP    = 2'd2;
    localparam logic [1:0] MODE_NOTCH = 2'd3;

    localparam logic [31:0] OMEGA_RESET      = 32'd562213;
    localparam logic [31:0] ANGLE_OCTANT_Q30 = 32'd1367130551;

    localparam longint Q30 = 64'sd1073741824;
    localparam t_val ONE_Q30     = t_val'(Q30);
    localparam t_val ALPHA_LIMIT = t_val'(32 * Q30 - 1);
    localparam t_val X_MAX       = t_val'(2 * Q30 - 1);
    localparam t_val X_MIN       = t_val'(-2 * Q30);

    // polynomial constants, 1e-8 units rounded to q.30
    localparam t_val PC0 = t_val'((64'sd70708592 * Q30 + 64'sd50000000) / 64'sd100000000);
    localparam t_val PC1 = t_val'((64'sd55535724 * Q30 + 64'sd50000000) / 64'sd100000000);
    localparam t_val PC2 = t_val'((64'sd21798592 * Q30 + 64'sd50000000) / 64'sd100000000);
    localparam t_val PC3 = t_val'((64'sd5707685 * Q30 + 64'sd50000000) / 64'sd100000000);
    localparam t_val PC4 = t_val'((64'sd1090000 * Q30 + 64'sd50000000) / 64'sd100000000);
    localparam t_val PC5 = t_val'((64'sd171961 * Q30 + 64'sd50000000) / 64'sd100000000);

    localparam logic [COEFF_W-1:0] OUT_MAX     = 18'd131071;
    localparam logic [COEFF_W-1:0] OUT_MIN_MAG = 18'd131072;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ANG,
        S_X,
        S_PSTART,
        S_PMUL,
        S_ASTART,
        S_ADIV,
        S_CSTART,
        S_CDIV,
        S_OUT
    } t_state;

    // constant added after the horner step k
    function automatic t_val poly_add(input logic [2:0] k);
        t_val v;
        unique case (k)
            3'd0:    v = PC4;
            3'd1:    v = PC3;
            3'd2:    v = -PC2;
            3'd3:    v = -PC1;
            default: v = PC0;
        endcase
        return v;
    endfunction

    function automatic logic [VAL_W-1:0] mag(input t_val v);
        return v[VAL_W-1] ? -v : v;
    endfunction

endpackage
`default_nettype wire

>>> rtl/bcc_mul.sv
// bit-serial shift and add multiplier, one multiplier bit per cycle
`default_nettype none
module bcc_mul (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bcc_pkg::t_mul_req        i_req,
    output logic                     o_done,
    output logic [bcc_pkg::MUL_P_W-1:0] o_prod
);
    import bcc_pkg::*;

    logic [MUL_A_W-1:0]   r_a;
    logic [MUL_P_W-1:0]   r_p;
    logic [MUL_P_W-1:0]   n_p;
    logic [MUL_A_W:0]     sum;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    always_comb begin
        sum = {1'b0, r_p[MUL_P_W-1:MUL_B_W]} + (r_p[0] ? {1'b0, r_a} : '0);
        n_p = {sum, r_p[MUL_B_W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= MUL_CNT_W'(MUL_B_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == MUL_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_p <= {{MUL_A_W{1'b0}}, i_req.b};
        end else if (r_busy) begin
            r_p <= n_p;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;

endmodule
`default_nettype wire

>>> rtl/bcc_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module bcc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bcc_pkg::t_div_req           i_req,
    output logic                        o_done,
    output logic [bcc_pkg::DIV_N_W-1:0] o_quot
);
    import bcc_pkg::*;

    logic [DIV_N_W-1:0]   r_q;
    logic [DIV_D_W:0]     r_rem;
    logic [DIV_D_W-1:0]   r_d;
    logic [DIV_D_W:0]     shifted;
    logic [DIV_D_W+1:0]   diff;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    always_comb begin
        shifted = {r_rem[DIV_D_W-1:0], r_q[DIV_N_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_N_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.num;
            r_d   <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            if (!diff[DIV_D_W+1]) begin
                r_rem <= diff[DIV_D_W:0];
                r_q   <= {r_q[DIV_N_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted;
                r_q   <= {r_q[DIV_N_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
`default_nettype wire

>>> rtl/biquad_coefficient_calculator.sv
// biquad coefficient calculator top level: sequencer around serial multiply and divide
// steps per item: angle multiply, x multiply, the cos and sin horner passes, the alpha divide,
//   the coefficient divides, then the output load
// a repeated item returns to idle after the angle multiply, with no result
// one item at a time; the next item is taken while the result waits
// synchronous active-low reset: idle, cache empty, mode low pass, omega_per_hz 562213
`default_nettype none
module biquad_coefficient_calculator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input items
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [23:0]          i_frequency,
    input  logic [23:0]          i_quality,
    // result items
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [17:0]   o_coeff_a1,
    output logic signed [17:0]   o_coeff_a2,
    output logic signed [17:0]   o_coeff_b0,
    output logic signed [17:0]   o_coeff_b1,
    output logic signed [17:0]   o_coeff_b2,
    // register writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);
    import bcc_pkg::*;

    // sequencer state and control
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   r_cache_valid, n_cache_valid;
    logic [1:0]  r_mode;
    logic [31:0] r_omega;

    // item and cache
    logic [23:0] r_qual, n_qual;
    logic [31:0] r_last_angle, n_last_angle;
    logic [23:0] r_last_qual, n_last_qual;

    // working values
    t_val r_x, n_x;
    t_val r_acc, n_acc;
    t_val r_c, n_c;
    t_val r_s, n_s;
    t_val r_alpha, n_alpha;
    t_val r_a0, n_a0;
    logic r_neg, n_neg;
    logic r_pass, n_pass;
    logic [2:0] r_k, n_k;
    logic [2:0] r_j, n_j;
    logic [COEFF_W-1:0] r_co [5];
    logic [COEFF_W-1:0] n_co;
    logic               co_we;
    logic [COEFF_W-1:0] r_o [5];
    logic               out_load;

    // shared units
    t_mul_req           mul_req;
    logic               mul_done;
    logic [MUL_P_W-1:0] mul_prod;
    t_div_req           div_req;
    logic               div_done;
    logic [DIV_N_W-1:0] div_quot;

    // helpers
    logic [MUL_P_W-1:0] ang_sum;
    logic [MUL_P_W-1:0] rnd_sum;
    logic [31:0]        angle;
    t_val               rnd30;
    t_val               x_raw;
    t_val               prod_s;
    t_val               v_cur;
    t_val               amag;
    t_val               alpha_new;
    t_val               a0_new;
    t_val               cnum;
    t_val               cden;
    logic [23:0]        qeff;
    logic [COEFF_W-1:0] qpos;
    logic [COEFF_W-1:0] qneg;

    bcc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    bcc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // arithmetic around the units
    always_comb begin
        // angle: product shifted right by 10, rounded, saturated to 32 bits
        ang_sum = mul_prod + MUL_P_W'(512);
        angle   = (|ang_sum[MUL_P_W-1:42]) ? 32'hFFFF_FFFF : ang_sum[41:10];
        // q.30 rounding of a product magnitude
        rnd_sum = mul_prod + (MUL_P_W'(1) << 29);
        rnd30   = t_val'(rnd_sum[MUL_P_W-1:30]);
        x_raw   = rnd30 - ONE_Q30;
        prod_s  = r_neg ? -rnd30 : rnd30;
        v_cur   = r_pass ? -r_x : r_x;
        // zero q is used as the smallest step
        qeff    = (r_qual == 24'd0) ? 24'd1 : r_qual;
        // alpha from the quotient, then a0
        amag      = (div_quot > DIV_N_W'(ALPHA_LIMIT)) ? ALPHA_LIMIT : t_val'(div_quot);
        alpha_new = r_s[VAL_W-1] ? -amag : amag;
        a0_new    = ONE_Q30 + alpha_new;
        if (a0_new < t_val'(1)) begin
            a0_new = t_val'(1);
        end
        // saturated coefficient from the quotient
        qpos = (div_quot > DIV_N_W'(OUT_MAX)) ? OUT_MAX : div_quot[COEFF_W-1:0];
        qneg = (div_quot > DIV_N_W'(OUT_MIN_MAG)) ? OUT_MIN_MAG : div_quot[COEFF_W-1:0];
    end

    // numerator and divisor of coefficient j
    always_comb begin
        cnum = ONE_Q30;
        cden = r_a0;
        unique case (r_j)
            3'd0: cnum = -(r_c <<< 1);
            3'd1: cnum = ONE_Q30 - r_alpha;
            3'd3: begin
                unique case (r_mode)
                    MODE_LP:    cnum = ONE_Q30 - r_c;
                    MODE_HP:    cnum = -(ONE_Q30 + r_c);
                    MODE_BP:    cnum = '0;
                    MODE_NOTCH: cnum = -(r_c <<< 1);
                endcase
            end
            default: begin
                // b0 and b2; b2 of band pass is negated
                unique case (r_mode)
                    MODE_LP: begin
                        cnum = ONE_Q30 - r_c;
                        cden = r_a0 <<< 1;
                    end
                    MODE_HP: begin
                        cnum = ONE_Q30 + r_c;
                        cden = r_a0 <<< 1;
                    end
                    MODE_BP:    cnum = (r_j == 3'd2) ? r_alpha : -r_alpha;
                    MODE_NOTCH: cnum = ONE_Q30;
                endcase
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid;
        n_cache_valid = r_cache_valid;
        n_qual        = r_qual;
        n_last_angle  = r_last_angle;
        n_last_qual   = r_last_qual;
        n_x           = r_x;
        n_acc         = r_acc;
        n_c           = r_c;
        n_s           = r_s;
        n_alpha       = r_alpha;
        n_a0          = r_a0;
        n_neg         = r_neg;
        n_pass        = r_pass;
        n_k           = r_k;
        n_j           = r_j;
        n_co          = r_neg ? COEFF_W'(18'd0 - qneg) : qpos;
        co_we         = 1'b0;
        out_load      = 1'b0;
        mul_req       = '0;
        div_req       = '0;

        // result taken downstream
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_qual        = i_quality;
                    mul_req.start = 1'b1;
                    mul_req.a     = MUL_A_W'(i_frequency);
                    mul_req.b     = r_omega;
                    n_state       = S_ANG;
                end
            end
            S_ANG: begin
                if (mul_done) begin
                    n_last_angle  = angle;
                    n_last_qual   = r_qual;
                    n_cache_valid = 1'b1;
                    // repeated angle and q give no result
                    if (r_cache_valid && angle == r_last_angle && r_qual == r_last_qual) begin
                        n_state = S_IDLE;
                    end else begin
                        mul_req.start = 1'b1;
                        mul_req.a     = MUL_A_W'(angle);
                        mul_req.b     = ANGLE_OCTANT_Q30;
                        n_state       = S_X;
                    end
                end
            end
            S_X: begin
                if (mul_done) begin
                    if (x_raw > X_MAX) begin
                        n_x = X_MAX;
                    end else begin
                        n_x = x_raw;
                    end
                    n_acc   = -PC5;
                    n_k     = 3'd0;
                    n_pass  = 1'b0;
                    n_state = S_PSTART;
                end
            end
            S_PSTART: begin
                // horner step: acc * v, cos pass with x, sin pass with -x
                mul_req.start = 1'b1;
                mul_req.a     = MUL_A_W'(mag(r_acc));
                mul_req.b     = MUL_B_W'(mag(v_cur));
                n_neg         = r_acc[VAL_W-1] ^ v_cur[VAL_W-1];
                n_state       = S_PMUL;
            end
            S_PMUL: begin
                if (mul_done) begin
                    n_acc   = prod_s + poly_add(r_k);
                    n_k     = r_k + 3'd1;
                    n_state = S_PSTART;
                    if (r_k == 3'd4) begin
                        n_k = 3'd0;
                        if (!r_pass) begin
                            n_c    = prod_s + poly_add(r_k);
                            n_acc  = -PC5;
                            n_pass = 1'b1;
                        end else begin
                            n_s     = prod_s + poly_add(r_k);
                            n_state = S_ASTART;
                        end
                    end
                end
            end
            S_ASTART: begin
                // alpha = round(|s| * 2^15 / q)
                div_req.start = 1'b1;
                div_req.num   = (DIV_N_W'(mag(r_s)) << ALPHA_SHIFT) + DIV_N_W'(qeff >> 1);
                div_req.den   = DIV_D_W'(qeff);
                n_state       = S_ADIV;
            end
            S_ADIV: begin
                if (div_done) begin
                    n_alpha = alpha_new;
                    n_a0    = a0_new;
                    n_j     = 3'd0;
                    n_state = S_CSTART;
                end
            end
            S_CSTART: begin
                div_req.start = 1'b1;
                div_req.num   = (DIV_N_W'(mag(cnum)) << COEFF_FRAC_BITS)
                              + DIV_N_W'(cden[VAL_W-1:1]);
                div_req.den   = DIV_D_W'(cden);
                n_neg         = cnum[VAL_W-1];
                n_state       = S_CDIV;
            end
            S_CDIV: begin
                if (div_done) begin
                    co_we = 1'b1;
                    n_j   = r_j + 3'd1;
                    if (r_j == 3'd4) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_CSTART;
                    end
                end
            end
            S_OUT: begin
                // wait until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_cache_valid <= 1'b0;
            r_last_angle  <= '0;
            r_last_qual   <= '0;
            r_mode        <= MODE_LP;
            r_omega       <= OMEGA_RESET;
        end else begin
            r_state       <= n_state;
            r_out_valid   <= n_out_valid;
            r_cache_valid <= n_cache_valid;
            r_last_angle  <= n_last_angle;
            r_last_qual   <= n_last_qual;
            // register writes, unknown indexes ignored
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_MODE) begin
                    r_mode <= i_cfg_data[1:0];
                end else if (i_cfg_index == REG_OMEGA) begin
                    r_omega <= i_cfg_data;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_qual  <= n_qual;
        r_x     <= n_x;
        r_acc   <= n_acc;
        r_c     <= n_c;
        r_s     <= n_s;
        r_alpha <= n_alpha;
        r_a0    <= n_a0;
        r_neg   <= n_neg;
        r_pass  <= n_pass;
        r_k     <= n_k;
        r_j     <= n_j;
        if (co_we) begin
            r_co[r_j] <= n_co;
        end
        if (out_load) begin
            r_o[0] <= r_co[0];
            r_o[1] <= r_co[1];
            r_o[2] <= r_co[2];
            r_o[3] <= r_co[3];
            r_o[4] <= r_co[4];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_coeff_a1  = r_o[0];
    assign o_coeff_a2  = r_o[1];
    assign o_coeff_b0  = r_o[2];
    assign o_coeff_b1  = r_o[3];
    assign o_coeff_b2  = r_o[4];

endmodule
`default_nettype wire

>>> rtl/bcc_checker.sv
// port checks for the biquad coefficient calculator, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module bcc_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic signed [17:0] o_coeff_a1,
    input wire logic signed [17:0] o_coeff_b0
);
    // one item at a time: busy right after an accepted item
    `BCC_ASSERT(a_busy_after_accept, (i_in_valid && !o_in_stall) |=> o_in_stall)
    // a stalled result stays offered
    `BCC_ASSERT(a_out_hold, (o_out_valid && i_out_stall) |=> o_out_valid)
    // a stalled result keeps its coefficients
    `BCC_ASSERT(a_out_stable, (o_out_valid && i_out_stall) |=> $stable({o_coeff_a1, o_coeff_b0}))
    // reset leaves the block idle with nothing to deliver
    `BCC_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (!o_out_valid && !o_in_stall))
endmodule

bind biquad_coefficient_calculator bcc_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_coeff_a1  (o_coeff_a1),
    .o_coeff_b0  (o_coeff_b0)
);
`default_nettype wire
